// ===== design/uptsg_pkg.sv =====
// ----------------------------------------------------------------------------
// uptsg_pkg
// Shared types and constants of the connector thermal short guard.
// ----------------------------------------------------------------------------
package uptsg_pkg;

    localparam int ROM_SIZE = 166;
    localparam logic [1:0] IV_NONE   = 2'd0;
    localparam logic [1:0] IV_NOW    = 2'd1;
    localparam logic [1:0] IV_FAST   = 2'd2;
    localparam logic [1:0] IV_NORMAL = 2'd3;

    localparam logic [2:0] REG_ENABLE = 3'd0;
    localparam logic [2:0] REG_THR    = 3'd1;
    localparam logic [2:0] REG_OPEN   = 3'd2;
    localparam logic [2:0] REG_CLOSE  = 3'd3;
    localparam logic [2:0] REG_FAST   = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic start;   // load item, begin averaging
        logic step;    // one table entry / divide step
        logic commit;  // apply state update
    } uptsg_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic search_done;
    } uptsg_sts_t;

    function automatic logic [10:0] ntc_code(input logic [7:0] idx);
        logic [10:0] r;
        begin
            case (idx)
            8'd0: r=1696; 8'd1: r=1690; 8'd2: r=1684; 8'd3: r=1678; 8'd4: r=1672;
            8'd5: r=1665; 8'd6: r=1658; 8'd7: r=1651; 8'd8: r=1644; 8'd9: r=1636;
            8'd10: r=1628; 8'd11: r=1619; 8'd12: r=1611; 8'd13: r=1602; 8'd14: r=1593;
            8'd15: r=1583; 8'd16: r=1573; 8'd17: r=1563; 8'd18: r=1553; 8'd19: r=1542;
            8'd20: r=1531; 8'd21: r=1519; 8'd22: r=1508; 8'd23: r=1496; 8'd24: r=1484;
            8'd25: r=1471; 8'd26: r=1458; 8'd27: r=1445; 8'd28: r=1431; 8'd29: r=1418;
            8'd30: r=1404; 8'd31: r=1389; 8'd32: r=1375; 8'd33: r=1360; 8'd34: r=1345;
            8'd35: r=1329; 8'd36: r=1314; 8'd37: r=1298; 8'd38: r=1282; 8'd39: r=1266;
            8'd40: r=1249; 8'd41: r=1233; 8'd42: r=1216; 8'd43: r=1199; 8'd44: r=1182;
            8'd45: r=1165; 8'd46: r=1148; 8'd47: r=1131; 8'd48: r=1113; 8'd49: r=1096;
            8'd50: r=1078; 8'd51: r=1061; 8'd52: r=1043; 8'd53: r=1025; 8'd54: r=1008;
            8'd55: r=990; 8'd56: r=973; 8'd57: r=955; 8'd58: r=938; 8'd59: r=920;
            8'd60: r=903; 8'd61: r=886; 8'd62: r=869; 8'd63: r=852; 8'd64: r=835;
            8'd65: r=818; 8'd66: r=802; 8'd67: r=785; 8'd68: r=769; 8'd69: r=753;
            8'd70: r=737; 8'd71: r=721; 8'd72: r=705; 8'd73: r=690; 8'd74: r=675;
            8'd75: r=660; 8'd76: r=645; 8'd77: r=631; 8'd78: r=617; 8'd79: r=603;
            8'd80: r=589; 8'd81: r=575; 8'd82: r=562; 8'd83: r=549; 8'd84: r=536;
            8'd85: r=523; 8'd86: r=511; 8'd87: r=499; 8'd88: r=487; 8'd89: r=475;
            8'd90: r=463; 8'd91: r=452; 8'd92: r=441; 8'd93: r=430; 8'd94: r=420;
            8'd95: r=410; 8'd96: r=400; 8'd97: r=390; 8'd98: r=380; 8'd99: r=371;
            8'd100: r=361; 8'd101: r=353; 8'd102: r=344; 8'd103: r=335; 8'd104: r=327;
            8'd105: r=319; 8'd106: r=311; 8'd107: r=304; 8'd108: r=296; 8'd109: r=289;
            8'd110: r=282; 8'd111: r=275; 8'd112: r=268; 8'd113: r=261; 8'd114: r=255;
            8'd115: r=249; 8'd116: r=243; 8'd117: r=237; 8'd118: r=231; 8'd119: r=225;
            8'd120: r=220; 8'd121: r=214; 8'd122: r=209; 8'd123: r=204; 8'd124: r=199;
            8'd125: r=194; 8'd126: r=190; 8'd127: r=185; 8'd128: r=181; 8'd129: r=176;
            8'd130: r=172; 8'd131: r=168; 8'd132: r=164; 8'd133: r=160; 8'd134: r=156;
            8'd135: r=152; 8'd136: r=149; 8'd137: r=145; 8'd138: r=142; 8'd139: r=138;
            8'd140: r=135; 8'd141: r=132; 8'd142: r=129; 8'd143: r=126; 8'd144: r=123;
            8'd145: r=120; 8'd146: r=117; 8'd147: r=115; 8'd148: r=112; 8'd149: r=109;
            8'd150: r=107; 8'd151: r=105; 8'd152: r=102; 8'd153: r=100; 8'd154: r=98;
            8'd155: r=95; 8'd156: r=93; 8'd157: r=91; 8'd158: r=89; 8'd159: r=87;
            8'd160: r=85; 8'd161: r=83; 8'd162: r=82; 8'd163: r=80; 8'd164: r=78;
            8'd165: r=76;
            default: r = 11'd0;
            endcase
            ntc_code = r;
        end
    endfunction

endpackage

// ===== design/uptsg_ctrl.sv =====
// ----------------------------------------------------------------------------
// uptsg_ctrl
// Sequencer: accept, divide steps, table search, commit, output hold.
// ----------------------------------------------------------------------------
module uptsg_ctrl
    import uptsg_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    output uptsg_cmd_t cmd,
    input  uptsg_sts_t sts
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_SRCH = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       mv_reg, mv_next;

    // a new item may be worked on while the previous result waits;
    // its commit holds until the output register is free
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = mv_reg;

    always_comb begin
        state_next = state_reg;
        mv_next    = mv_reg && !m_ready;
        cmd        = '0;
        case (state_reg)
        ST_IDLE: begin
            if (s_valid && s_ready) begin
                cmd.start  = 1'b1;
                state_next = ST_DIV;
            end
        end
        ST_DIV: begin
            cmd.step = 1'b1;
            if (sts.div_done) state_next = ST_SRCH;
        end
        ST_SRCH: begin
            cmd.step = 1'b1;
            if (sts.search_done) state_next = ST_OUT;
        end
        ST_OUT: begin
            if (!mv_reg || m_ready) begin
                cmd.commit = 1'b1;
                mv_next    = 1'b1;
                state_next = ST_IDLE;
            end
        end
        default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end
endmodule

// ===== design/uptsg_dp.sv =====
// ----------------------------------------------------------------------------
// uptsg_dp
// Datapath: sample average by restoring divide, table search, guard state.
// ----------------------------------------------------------------------------
module uptsg_dp
    import uptsg_pkg::*;
#(
    parameter int TABLE_ENTRIES = 166,
    parameter int SAMPLE_COUNT  = 3,
    parameter int INSERT_CHECKS = 1100,
    parameter int END_CHECK     = 1001,
    parameter int ADC_BITS      = 12
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  uptsg_cmd_t        cmd,
    output uptsg_sts_t        sts,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    input  logic              s_action,
    input  logic [11:0]       s_adc_sample_a,
    input  logic [11:0]       s_adc_sample_b,
    input  logic [11:0]       s_adc_sample_c,
    input  logic [2:0]        s_sample_valid_mask,
    input  logic signed [7:0] s_battery_temp,
    input  logic              s_battery_temp_valid,
    input  logic              s_charger_absent,
    output logic              m_gate_on,
    output logic              m_short_alarm,
    output logic [1:0]        m_next_interval,
    output logic              m_fast_mode,
    output logic              m_wake_hold,
    output logic signed [7:0] m_usb_temp,
    output logic signed [11:0] m_check_count_out
);
    localparam int NENT = (TABLE_ENTRIES < ROM_SIZE) ? TABLE_ENTRIES : ROM_SIZE;
    localparam int SUMW = ADC_BITS + 2;
    localparam logic [SUMW-1:0] AMASK = {2'b00, {ADC_BITS{1'b1}}};
    localparam logic signed [11:0] C_INS = 12'(INSERT_CHECKS);
    localparam logic signed [11:0] C_END = 12'(END_CHECK);
    localparam logic [7:0] LAST = 8'(NENT - 1);

    // config
    logic       en_reg;
    logic signed [7:0] thr_reg, od_reg, cd_reg, fd_reg;
    // item
    logic       act_reg, babs_reg, bv_reg;
    logic signed [7:0] bt_reg;
    // divide / search
    logic [SUMW-1:0] quo_reg, rem_reg;
    logic [1:0]      cnt_reg;
    logic [4:0]      dbit_reg;
    logic            ddone_reg;
    logic [7:0]      idx_reg;
    logic            found_reg;
    // guard state
    logic signed [11:0] cc_reg;
    logic gate_reg, armed_reg, fast_reg, wake_reg, active_reg;
    // outputs
    logic       alarm_reg;
    logic [1:0] iv_reg;
    logic signed [7:0] tusb_reg;
    logic       gate_o_reg, fast_o_reg, wake_o_reg;
    logic signed [11:0] cc_o_reg;

    logic [SUMW-1:0] sum_w, sa, sb, sc;
    logic [1:0]      cnt_w;
    logic [SUMW-1:0] rem_sh;
    logic            hit;

    always_comb begin
        sa = (s_sample_valid_mask[0]) ?
             ({{(SUMW-12){1'b0}}, s_adc_sample_a} & AMASK) : '0;
        sb = (s_sample_valid_mask[1] && SAMPLE_COUNT > 1) ?
             ({{(SUMW-12){1'b0}}, s_adc_sample_b} & AMASK) : '0;
        sc = (s_sample_valid_mask[2] && SAMPLE_COUNT > 2) ?
             ({{(SUMW-12){1'b0}}, s_adc_sample_c} & AMASK) : '0;
        sum_w = sa + sb + sc;
        cnt_w = 2'(s_sample_valid_mask[0])
              + ((SAMPLE_COUNT > 1) ? 2'(s_sample_valid_mask[1]) : 2'd0)
              + ((SAMPLE_COUNT > 2) ? 2'(s_sample_valid_mask[2]) : 2'd0);
    end

    assign rem_sh = {rem_reg[SUMW-2:0], quo_reg[SUMW-1]};
    assign hit    = ({{(SUMW-11){1'b0}}, ntc_code(idx_reg)} <= quo_reg);
    assign sts.div_done    = ddone_reg;
    assign sts.search_done = ddone_reg && (found_reg || hit || idx_reg == LAST);

    // guard update
    logic signed [9:0]  tusb_w, tbatt, raw, diff;
    logic               meas, alarm_n, gate_n, armed_n, fast_n, wake_n, act_n;
    logic signed [11:0] cc_n;
    logic [1:0]         iv_n;
    always_comb begin
        meas = 1'b0;
        alarm_n = 1'b0; gate_n = gate_reg; armed_n = armed_reg; fast_n = fast_reg;
        wake_n = wake_reg; act_n = active_reg; cc_n = cc_reg; iv_n = IV_NONE;
        tusb_w = (cnt_reg == 2'd0) ? 10'sd0 : (10'sd0 - 10'sd40 + $signed({2'b00, idx_reg}));
        tbatt = bv_reg ? 10'(bt_reg) : -10'sd255;
        raw  = tusb_w - tbatt;
        diff = bv_reg ? raw : 10'sd0;
        if (!act_reg) begin
            if (en_reg && !active_reg) begin
                cc_n = C_INS; act_n = 1'b1; iv_n = IV_NOW;
            end
        end else if (active_reg) begin
            if (cc_reg == -12'sd1 && babs_reg) begin
                act_n = 1'b0; armed_n = 1'b1; gate_n = 1'b0; fast_n = 1'b0; cc_n = C_INS;
            end else begin
                meas = 1'b1;
                if (tusb_w >= 10'(thr_reg) && diff >= 10'(od_reg) && armed_reg) begin
                    alarm_n = 1'b1; armed_n = 1'b0;
                end
                if (diff > 10'(fd_reg)) begin
                    iv_n = IV_FAST; cc_n = '0; fast_n = 1'b1;
                end else if (cc_reg > C_END) begin
                    cc_n = cc_reg - 12'sd1; iv_n = IV_FAST; fast_n = 1'b0;
                end else if (cc_reg == C_END) begin
                    cc_n = -12'sd1; iv_n = IV_NORMAL; fast_n = 1'b0; wake_n = 1'b0;
                end else if (cc_reg >= 12'sd0) begin
                    cc_n = cc_reg + 12'sd1; iv_n = IV_FAST; fast_n = 1'b1;
                end else begin
                    iv_n = IV_NORMAL; fast_n = 1'b0;
                end
                if (bv_reg && tusb_w >= 10'(thr_reg) && raw >= 10'(od_reg)) begin
                    wake_n = 1'b1; gate_n = 1'b1;
                end else if (raw <= 10'(cd_reg)) begin
                    gate_n = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            act_reg <= s_action; babs_reg <= s_charger_absent;
            bv_reg <= s_battery_temp_valid; bt_reg <= s_battery_temp;
            quo_reg <= sum_w; rem_reg <= '0; cnt_reg <= cnt_w;
            dbit_reg <= 5'(SUMW); ddone_reg <= (cnt_w == 2'd0);
            idx_reg <= '0; found_reg <= 1'b0;
        end else if (cmd.step) begin
            if (!ddone_reg) begin
                // restoring divide by sample count, one quotient bit per cycle
                if (rem_sh >= {{(SUMW-2){1'b0}}, cnt_reg}) begin
                    rem_reg <= rem_sh - {{(SUMW-2){1'b0}}, cnt_reg};
                    quo_reg <= {quo_reg[SUMW-2:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[SUMW-2:0], 1'b0};
                end
                dbit_reg <= dbit_reg - 5'd1;
                if (dbit_reg == 5'd1) ddone_reg <= 1'b1;
            end else if (!found_reg && !hit && idx_reg != LAST && cnt_reg != 2'd0) begin
                idx_reg <= idx_reg + 8'd1;
            end else begin
                found_reg <= 1'b1;
            end
        end
        if (cmd.commit) begin
            alarm_reg <= alarm_n; iv_reg <= iv_n;
            tusb_reg <= meas ? tusb_w[7:0] : 8'sd0;
            gate_o_reg <= gate_n; fast_o_reg <= fast_n; wake_o_reg <= wake_n;
            cc_o_reg <= cc_n;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg <= 1'b0; thr_reg <= 8'sd40; od_reg <= 8'sd15;
            cd_reg <= 8'sd10; fd_reg <= 8'sd10;
            cc_reg <= C_INS; gate_reg <= 1'b0; armed_reg <= 1'b1;
            fast_reg <= 1'b0; wake_reg <= 1'b0; active_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                REG_ENABLE: en_reg  <= cfg_data[0];
                REG_THR:    thr_reg <= cfg_data;
                REG_OPEN:   od_reg  <= cfg_data;
                REG_CLOSE:  cd_reg  <= cfg_data;
                REG_FAST:   fd_reg  <= cfg_data;
                default: ;
                endcase
            end
            if (cmd.commit) begin
                cc_reg <= cc_n; gate_reg <= gate_n; armed_reg <= armed_n;
                fast_reg <= fast_n; wake_reg <= wake_n; active_reg <= act_n;
            end
        end
    end

    assign m_gate_on         = gate_o_reg;
    assign m_short_alarm     = alarm_reg;
    assign m_next_interval   = iv_reg;
    assign m_fast_mode       = fast_o_reg;
    assign m_wake_hold       = wake_o_reg;
    assign m_usb_temp        = tusb_reg;
    assign m_check_count_out = cc_o_reg;
endmodule

// ===== design/usb_port_thermal_short_guard_core.sv =====
// ----------------------------------------------------------------------------
// usb_port_thermal_short_guard_core
// Connector thermal short guard: attach/check sequencing and cut-off gate.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (s_valid/s_ready) carry one attach event or check tick with
//   up to three thermistor ADC samples and the battery temperature. Each
//   item gives exactly one result on m_valid/m_ready. The user must write the
//   registers via cfg_we/cfg_index/cfg_data only while idle; it is unenforced.
// Sequence:
//   restoring divide over ADC_BITS+2 quotient bits, one quotient bit per cycle,
//   then the NTC table scan at one entry per cycle, then the commit. The scan
//   stops at the first entry whose code is at or below the average, or at the
//   last entry; with no valid sample no divide bits are worked.
//   The next item is accepted the cycle after commit: one item in flight.
// Reset (aresetn low, synchronous): registers 0/40/15/10/10, counter 1100,
//   gate closed, alarm armed, checking stopped.
// Stall: a result waits in the output register until m_ready; the next item
//   is taken and worked on meanwhile, and its commit waits for the register.
// ----------------------------------------------------------------------------
module usb_port_thermal_short_guard_core
    import uptsg_pkg::*;
#(
    parameter int TABLE_ENTRIES = 166,
    parameter int SAMPLE_COUNT  = 3,
    parameter int INSERT_CHECKS = 1100,
    parameter int END_CHECK     = 1001,
    parameter int ADC_BITS      = 12
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_action,
    input  logic [11:0]       s_adc_sample_a,
    input  logic [11:0]       s_adc_sample_b,
    input  logic [11:0]       s_adc_sample_c,
    input  logic [2:0]        s_sample_valid_mask,
    input  logic signed [7:0] s_battery_temp,
    input  logic              s_battery_temp_valid,
    input  logic              s_charger_absent,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_gate_on,
    output logic              m_short_alarm,
    output logic [1:0]        m_next_interval,
    output logic              m_fast_mode,
    output logic              m_wake_hold,
    output logic signed [7:0] m_usb_temp,
    output logic signed [11:0] m_check_count_out
);
    uptsg_cmd_t cmd;
    uptsg_sts_t sts;

    uptsg_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .cmd(cmd), .sts(sts)
    );

    uptsg_dp #(
        .TABLE_ENTRIES(TABLE_ENTRIES), .SAMPLE_COUNT(SAMPLE_COUNT),
        .INSERT_CHECKS(INSERT_CHECKS), .END_CHECK(END_CHECK), .ADC_BITS(ADC_BITS)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_action(s_action), .s_adc_sample_a(s_adc_sample_a),
        .s_adc_sample_b(s_adc_sample_b), .s_adc_sample_c(s_adc_sample_c),
        .s_sample_valid_mask(s_sample_valid_mask), .s_battery_temp(s_battery_temp),
        .s_battery_temp_valid(s_battery_temp_valid), .s_charger_absent(s_charger_absent),
        .m_gate_on(m_gate_on), .m_short_alarm(m_short_alarm),
        .m_next_interval(m_next_interval), .m_fast_mode(m_fast_mode),
        .m_wake_hold(m_wake_hold), .m_usb_temp(m_usb_temp),
        .m_check_count_out(m_check_count_out)
    );
endmodule
